@@ rtl/point_in_polygon_nearest_edge_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef POINT_IN_POLYGON_NEAREST_EDGE_MACROS_SVH
`define POINT_IN_POLYGON_NEAREST_EDGE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PIPNE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PIPNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pipne_pkg.sv @@
package pipne_pkg;

  localparam int MAX_VERTICES = 32;

  // limit^2 = 1e8 << 20 in Q.20
  localparam logic [26:0] LIMIT_SQ_MANT  = 27'd100000000;
  localparam int          LIMIT_SQ_SHIFT = 20;
  localparam logic [46:0] LIMIT_SQ       = 47'd104857600000000;

  localparam logic [1:0] ST_INSIDE   = 2'd0;
  localparam logic [1:0] ST_NEAR     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage

@@ rtl/point_in_polygon_nearest_edge.sv @@
// A plain vertex runs S_CALC, then S_UPD (edge ends on an endpoint) or S_DIV and S_UPD
// (interior projection, restoring divide unless saturated); a non-final first vertex loads.
// The final vertex adds the closing edge, S_TOL and S_FIN, then done pulses for one cycle.
// One item at a time: busy stays high while the shared 34x34 multiplier works an edge;
// the result beat is never stalled.
// Synchronous active-high reset clears the polygon state and the tolerance register.
module point_in_polygon_nearest_edge
  import pipne_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               final_vertex,
  input  logic               cfg_wr_en,
  input  logic        [30:0] cfg_wr_data,
  output logic               done,
  output logic         [1:0] status,
  output logic         [4:0] nearest_edge
);

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_DIV, S_UPD, S_TOL, S_FIN} state_t;

  state_t state;
  logic [3:0]  step;
  logic [30:0] edge_tolerance;
  logic signed [31:0] pnt_x, pnt_y, first_x, first_y, prev_x, prev_y;
  logic signed [31:0] ev_x, ev_y, ew_x, ew_y;
  logic [5:0]  vcount;
  logic        parity;
  logic [46:0] best;
  logic [4:0]  best_edge;
  logic        closing;
  logic        fin_pend;
  logic [4:0]  edge_idx;
  logic signed [67:0] prod, t0, p6, p7;
  logic signed [66:0] dot, len, crs;
  logic [131:0] num, lim, rem, dvs;
  logic [45:0] quo;
  logic [5:0]  div_cnt;
  logic [46:0] edge_dsq;

  logic signed [32:0] dx, dy, ex, ey, fx, fy, ux, uy;
  logic signed [33:0] mul_a, mul_b;
  logic signed [66:0] cneg;
  logic [65:0] cmag;
  logic [32:0] cl, ch, ll, lh;
  logic        ep_start, ep_end, interior;
  logic [66:0] esum;
  logic [46:0] esat;
  logic        rem_ge;
  logic [131:0] rem_sub;
  logic        side, crosses, take;
  logic [61:0] tol2;

  assign busy = (state != S_IDLE);

  always_comb begin
    dx = {ew_x[31], ew_x} - {ev_x[31], ev_x};
    dy = {ew_y[31], ew_y} - {ev_y[31], ev_y};
    ex = {pnt_x[31], pnt_x} - {ev_x[31], ev_x};
    ey = {pnt_y[31], pnt_y} - {ev_y[31], ev_y};
    fx = {pnt_x[31], pnt_x} - {ew_x[31], ew_x};
    fy = {pnt_y[31], pnt_y} - {ew_y[31], ew_y};
    ep_start = dot[66] || (dot == '0);
    ep_end   = !ep_start && (dot >= len);
    interior = !ep_start && !ep_end;
    ux = ep_start ? ex : fx;
    uy = ep_start ? ey : fy;
    cneg = -crs;
    cmag = crs[66] ? cneg[65:0] : crs[65:0];
    cl = cmag[32:0];
    ch = cmag[65:33];
    ll = len[32:0];
    lh = len[65:33];
    esum = {1'b0, t0[65:0]} + {1'b0, prod[65:0]};
    esat = (esum < {20'd0, LIMIT_SQ}) ? esum[46:0] : LIMIT_SQ;
    rem_ge  = (rem >= dvs);
    rem_sub = rem - dvs;
    side    = (ew_y > pnt_y) != (ev_y > pnt_y);
    crosses = side && (dy[32] ? (p6 > p7) : (p6 < p7));
    take    = closing ? ((edge_dsq < LIMIT_SQ) && (edge_dsq <= best)) : (edge_dsq < best);
    tol2    = prod[61:0];

    mul_a = '0;
    mul_b = '0;
    if (state == S_CALC) begin
      case (step)
        4'd0: begin mul_a = {ex[32], ex}; mul_b = {dx[32], dx}; end
        4'd1: begin mul_a = {ey[32], ey}; mul_b = {dy[32], dy}; end
        4'd2: begin mul_a = {dx[32], dx}; mul_b = {dx[32], dx}; end
        4'd3: begin mul_a = {dy[32], dy}; mul_b = {dy[32], dy}; end
        4'd4: begin mul_a = {ex[32], ex}; mul_b = {dy[32], dy}; end
        4'd5: begin mul_a = {ey[32], ey}; mul_b = {dx[32], dx}; end
        4'd6: begin mul_a = {fx[32], fx}; mul_b = {dy[32], dy}; end
        4'd7: begin mul_a = {dx[32], dx}; mul_b = {fy[32], fy}; end
        4'd8: begin
          if (interior) begin
            mul_a = {1'b0, cl}; mul_b = {1'b0, cl};
          end else begin
            mul_a = {ux[32], ux}; mul_b = {ux[32], ux};
          end
        end
        4'd9: begin
          if (interior) begin
            mul_a = {1'b0, cl}; mul_b = {1'b0, ch};
          end else begin
            mul_a = {uy[32], uy}; mul_b = {uy[32], uy};
          end
        end
        4'd10: begin mul_a = {1'b0, ch}; mul_b = {1'b0, cl}; end
        4'd11: begin mul_a = {1'b0, ch}; mul_b = {1'b0, ch}; end
        4'd12: begin mul_a = {1'b0, ll}; mul_b = {7'd0, LIMIT_SQ_MANT}; end
        4'd13: begin mul_a = {1'b0, lh}; mul_b = {7'd0, LIMIT_SQ_MANT}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_TOL) begin
      mul_a = {3'd0, edge_tolerance};
      mul_b = {3'd0, edge_tolerance};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= '0;
      edge_tolerance <= '0;
      vcount         <= '0;
      parity         <= 1'b0;
      best           <= LIMIT_SQ;
      best_edge      <= '0;
      closing        <= 1'b0;
      fin_pend       <= 1'b0;
      done           <= 1'b0;
      status         <= ST_INSIDE;
      nearest_edge   <= '0;
    end else begin
      prod <= mul_a * mul_b;
      done <= 1'b0;
      if (cfg_wr_en) edge_tolerance <= cfg_wr_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            step <= '0;
            fin_pend <= final_vertex;
            if (vcount == '0) begin
              pnt_x   <= point_x;
              pnt_y   <= point_y;
              first_x <= vertex_x;
              first_y <= vertex_y;
              prev_x  <= vertex_x;
              prev_y  <= vertex_y;
              ev_x    <= vertex_x;
              ev_y    <= vertex_y;
              ew_x    <= vertex_x;
              ew_y    <= vertex_y;
              closing <= 1'b1;
              edge_idx <= '0;
              vcount  <= 6'd1;
              if (final_vertex) state <= S_CALC;
            end else if (vcount < 6'(MAX_VERTICES)) begin
              ev_x    <= prev_x;
              ev_y    <= prev_y;
              ew_x    <= vertex_x;
              ew_y    <= vertex_y;
              prev_x  <= vertex_x;
              prev_y  <= vertex_y;
              closing <= 1'b0;
              edge_idx <= 5'(vcount - 6'd1);
              vcount  <= vcount + 6'd1;
              state   <= S_CALC;
            end else begin
              vcount <= 6'(MAX_VERTICES + 1);
              if (final_vertex) state <= S_TOL;
            end
          end
        end
        S_CALC: begin
          step <= step + 4'd1;
          case (step)
            4'd1: t0 <= prod;
            4'd2: dot <= 67'(t0) + 67'(prod);
            4'd3: t0 <= prod;
            4'd4: len <= 67'(t0) + 67'(prod);
            4'd5: t0 <= prod;
            4'd6: crs <= 67'(t0) - 67'(prod);
            4'd7: p6 <= prod;
            4'd8: p7 <= prod;
            4'd9: begin
              if (interior) num <= {66'd0, prod[65:0]};
              else t0 <= prod;
            end
            4'd10: begin
              if (interior) begin
                num <= num + ({66'd0, prod[65:0]} << 33);
              end else begin
                edge_dsq <= esat;
                state    <= S_UPD;
              end
            end
            4'd11: num <= num + ({66'd0, prod[65:0]} << 33);
            4'd12: num <= num + ({66'd0, prod[65:0]} << 66);
            4'd13: lim <= {66'd0, prod[65:0]};
            4'd14: lim <= (lim + ({66'd0, prod[65:0]} << 33)) << LIMIT_SQ_SHIFT;
            4'd15: begin
              if (num >= lim) begin
                edge_dsq <= LIMIT_SQ;
                state    <= S_UPD;
              end else begin
                rem     <= num;
                dvs     <= {66'd0, len[65:0]} << 46;
                div_cnt <= 6'd46;
                state   <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (rem_ge) rem <= rem_sub;
          quo <= {quo[44:0], rem_ge};
          dvs <= dvs >> 1;
          if (div_cnt == '0) begin
            edge_dsq <= {quo, rem_ge};
            state    <= S_UPD;
          end else begin
            div_cnt <= div_cnt - 6'd1;
          end
        end
        S_UPD: begin
          if (take) begin
            best      <= edge_dsq;
            best_edge <= edge_idx;
          end
          if (crosses) parity <= !parity;
          step <= '0;
          if (fin_pend && !closing) begin
            ev_x     <= prev_x;
            ev_y     <= prev_y;
            ew_x     <= first_x;
            ew_y     <= first_y;
            closing  <= 1'b1;
            edge_idx <= 5'(vcount - 6'd1);
            state    <= S_CALC;
          end else if (fin_pend) begin
            state <= S_TOL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TOL: state <= S_FIN;
        S_FIN: begin
          done <= 1'b1;
          nearest_edge <= '0;
          if (vcount > 6'(MAX_VERTICES)) begin
            status <= ST_OVERFLOW;
          end else if (parity) begin
            status <= ST_INSIDE;
          end else if ((best < LIMIT_SQ) && ({15'd0, best} <= tol2)) begin
            status <= ST_NEAR;
            nearest_edge <= best_edge;
          end else begin
            status <= ST_OUTSIDE;
          end
          vcount    <= '0;
          parity    <= 1'b0;
          best      <= LIMIT_SQ;
          best_edge <= '0;
          fin_pend  <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/pipne_chk.sv @@
`include "point_in_polygon_nearest_edge_macros.svh"

module pipne_chk
  import pipne_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       final_vertex,
  input logic       done,
  input logic [1:0] status,
  input logic [4:0] nearest_edge
);

  `PIPNE_ASSERT(a_done_idle, done, !busy, "result beat while busy")
  `PIPNE_ASSERT(a_done_from_busy, done, $past(busy), "result beat without work")
  `PIPNE_ASSERT_NEXT(a_single_beat, done, !done, "result repeated")
  `PIPNE_ASSERT(a_edge_zero, done && (status != ST_NEAR), nearest_edge == 5'd0, "stray edge index")
  `PIPNE_ASSERT_NEXT(a_final_works, start && !busy && final_vertex, busy, "final vertex ignored")

endmodule

bind point_in_polygon_nearest_edge pipne_chk u_pipne_chk (.*);

@@ test/point_in_polygon_nearest_edge_tb.sv @@
module point_in_polygon_nearest_edge_tb;
  import pipne_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [159:0] big_t;
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] edge_idx;
  } verdict_t;

  localparam longint LIMIT_DIST = 64'd10240000;
  localparam longint LIMIT_SQ64 = 64'd104857600000000;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;

  logic clk = 0, rst = 1, start = 0, final_vertex = 0, cfg_wr_en = 0;
  logic signed [31:0] vertex_x = 0, vertex_y = 0, point_x = 0, point_y = 0;
  logic [30:0] cfg_wr_data = 0;
  logic busy, done;
  logic [1:0] status;
  logic [4:0] nearest_edge;

  point_in_polygon_nearest_edge dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .point_x(point_x), .point_y(point_y),
    .final_vertex(final_vertex), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .done(done), .status(status), .nearest_edge(nearest_edge)
  );

  always #5 clk = ~clk;

  // predictor state
  longint tol;
  longint first_x, first_y, prev_x, prev_y, pt_x, pt_y;
  int unsigned vcount;
  bit parity;
  longint best_sq;
  int unsigned best_idx;

  verdict_t verdicts[$];
  int errors = 0, beats = 0, results = 0, polygons = 0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint endpoint_sq(longint ex, longint ey);
    longint s;
    if (mag(ex) > LIMIT_DIST || mag(ey) > LIMIT_DIST) return LIMIT_SQ64;
    s = ex * ex + ey * ey;
    return s < LIMIT_SQ64 ? s : LIMIT_SQ64;
  endfunction

  function automatic longint seg_dist_sq(longint vx, longint vy, longint wx, longint wy);
    big_t dx, dy, ex, ey, dot, len, cr, num, q;
    dx = wx - vx; dy = wy - vy; ex = pt_x - vx; ey = pt_y - vy;
    dot = ex * dx + ey * dy;
    len = dx * dx + dy * dy;
    if (dot <= 0) return endpoint_sq(pt_x - vx, pt_y - vy);
    if (dot >= len) return endpoint_sq(pt_x - wx, pt_y - wy);
    cr = ex * dy - ey * dx;
    num = cr * cr;
    if (num >= len * big_t'(LIMIT_SQ64)) return LIMIT_SQ64;
    q = num / len;
    return longint'(q);
  endfunction

  function automatic bit ray_crosses(longint px, longint py, longint cx, longint cy);
    big_t den, lhs, rhs;
    if ((cy > pt_y) == (py > pt_y)) return 0;
    den = py - cy;
    lhs = big_t'(pt_x - cx) * den;
    rhs = big_t'(px - cx) * big_t'(pt_y - cy);
    return den > 0 ? lhs < rhs : lhs > rhs;
  endfunction

  function automatic void add_edge(longint px, longint py, longint cx, longint cy,
                                   int unsigned idx, bit closing);
    longint d;
    bit take;
    d = seg_dist_sq(px, py, cx, cy);
    take = closing ? (d < LIMIT_SQ64 && d <= best_sq) : (d < best_sq);
    if (take) begin
      best_sq = d;
      best_idx = idx;
    end
    if (ray_crosses(px, py, cx, cy)) parity = ~parity;
  endfunction

  function automatic void clear_poly();
    vcount = 0; parity = 0; best_sq = LIMIT_SQ64; best_idx = 0;
  endfunction

  function automatic void predict_vertex(longint vx, longint vy, longint px, longint py,
                                         bit fin);
    verdict_t r;
    if (vcount == 0) begin
      pt_x = px; pt_y = py;
      first_x = vx; first_y = vy; prev_x = vx; prev_y = vy;
      vcount = 1;
    end else if (vcount < MAX_VERTICES) begin
      add_edge(prev_x, prev_y, vx, vy, vcount - 1, 0);
      prev_x = vx; prev_y = vy;
      vcount++;
    end else begin
      vcount = MAX_VERTICES + 1;
    end
    if (!fin) return;
    r.edge_idx = '0;
    if (vcount > MAX_VERTICES) begin
      r.status = ST_OVERFLOW;
    end else begin
      add_edge(prev_x, prev_y, first_x, first_y, vcount - 1, 1);
      if (parity) r.status = ST_INSIDE;
      else if (best_sq < LIMIT_SQ64 && best_sq <= tol * tol) begin
        r.status = ST_NEAR;
        r.edge_idx = best_idx[4:0];
      end else r.status = ST_OUTSIDE;
    end
    verdicts.insert(verdicts.size(), r);
    clear_poly();
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      results++;
      if (verdicts.size() == 0) begin
        report("unexpected result", status, -1);
      end else begin
        verdict_t w;
        w = verdicts.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (nearest_edge !== w.edge_idx) report("nearest_edge", nearest_edge, w.edge_idx);
      end
    end
  end

  bit random_gaps = 1;

  task automatic send_vertex(longint vx, longint vy, longint px, longint py, bit fin);
    int gap;
    gap = random_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    vertex_x = 32'(vx); vertex_y = 32'(vy); point_x = 32'(px); point_y = 32'(py);
    final_vertex = fin;
    start = 1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_vertex(longint'(vertex_x), longint'(vertex_y), longint'(point_x),
                   longint'(point_y), fin);
    beats++;
    if (fin) polygons++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (verdicts.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_tolerance(longint v);
    drain();
    cfg_wr_data = v[30:0];
    cfg_wr_en = 1;
    @(negedge clk);
    cfg_wr_en = 0;
    tol = v;
  endtask

  task automatic send_square(longint x0, longint y0, longint s, longint px, longint py);
    send_vertex(x0, y0, px, py, 0);
    send_vertex(x0 + s, y0, $urandom, $urandom, 0);
    send_vertex(x0 + s, y0 + s, $urandom, $urandom, 0);
    send_vertex(x0, y0 + s, $urandom, $urandom, 1);
  endtask

  task automatic test_directed();
    write_tolerance(2048);
    send_square(0, 0, 4096, 1024, 1024);
    send_square(0, 0, 4096, 5000, 2048);
    send_square(0, 0, 4096, 99999, 2048);
    send_square(0, 0, 4096, -2048, 2048);
    send_vertex(100, 100, 200, 200, 1);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0);
    send_vertex(COORD_MAX, COORD_MAX, 0, 0, 0);
    send_vertex(COORD_MAX, COORD_MAX, 0, 0, 1);
    send_vertex(10, 10, 0, 0, 0);
    send_vertex(10, 10, 0, 0, 1);
    write_tolerance(31'h7fffffff);
    send_square(0, 0, 4096, 5000, 2048);
    send_square(0, 0, 4096, 2048, -1000);
    for (int i = 0; i < 34; i++) send_vertex(i * 64, (i % 2) * 512, 0, 0, i == 33);
  endtask

  task automatic test_random();
    int n, nv;
    longint cx, cy, spread, vx, vy;
    bit wild;
    n = 0;
    while (n < 580) begin
      if ($urandom_range(0, 49) == 0) begin
        longint tv;
        case ($urandom_range(0, 3))
          0: tv = 0;
          1: tv = 31'h7fffffff;
          2: tv = $urandom_range(0, 1 << 16);
          default: tv = $urandom & 32'h7fffffff;
        endcase
        write_tolerance(tv);
      end
      if ($urandom_range(0, 29) == 0) drain();
      random_gaps = $urandom_range(0, 5) != 0;
      wild = $urandom_range(0, 9) == 0;
      nv = $urandom_range(0, 19) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 7);
      cx = longint'($signed($urandom)) >>> $urandom_range(4, 12);
      cy = longint'($signed($urandom)) >>> $urandom_range(4, 12);
      spread = 1 << $urandom_range(8, 24);
      for (int k = 0; k < nv; k++) begin
        if (wild) begin
          vx = longint'($signed($urandom)); vy = longint'($signed($urandom));
        end else begin
          vx = cx + $urandom_range(0, 2 * spread) - spread;
          vy = cy + $urandom_range(0, 2 * spread) - spread;
          if (vx > COORD_MAX) vx = COORD_MAX;
          if (vx < COORD_MIN) vx = COORD_MIN;
          if (vy > COORD_MAX) vy = COORD_MAX;
          if (vy < COORD_MIN) vy = COORD_MIN;
        end
        if (wild) send_vertex(vx, vy, longint'($signed($urandom)), longint'($signed($urandom)),
                              k == nv - 1);
        else send_vertex(vx, vy, cx + $urandom_range(0, spread) - spread / 2,
                         cy + $urandom_range(0, spread) - spread / 2, k == nv - 1);
        n++;
      end
    end
  endtask

  initial begin
    tol = 0;
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; pt_x = 0; pt_y = 0;
    clear_poly();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random();
    drain();
    $display("sent %0d vertex beats in %0d polygons, checked %0d results",
             beats, polygons, results);
    if (errors == 0) $display("point_in_polygon_nearest_edge_tb: done, clean");
    else $display("point_in_polygon_nearest_edge_tb: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("point_in_polygon_nearest_edge_tb: done, errors");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/pipne_pkg.sv
rtl/point_in_polygon_nearest_edge.sv
rtl/pipne_chk.sv
test/point_in_polygon_nearest_edge_tb.sv
